// ===== rtl/hufd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and codes for the Huffman tree-walk decoder.
package hufd_pkg;

	localparam int NODE_COUNT_DEF = 512;
	localparam int SYMBOL_COUNT   = 256;

	localparam int IDX_W  = 9;
	localparam int SYM_W  = 8;
	localparam int VB_W   = 4;
	localparam int MODE_W = 2;
	localparam int IN_W   = 48;
	localparam int OUT_W  = 8;

	localparam logic [VB_W-1:0] BYTE_BITS = 4'd8;

	localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DECODE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

	typedef struct packed {
		logic [SYM_W-1:0] sym;
		logic             leaf;
		logic [IDX_W-1:0] right;
		logic [IDX_W-1:0] left;
	} entry_t;

	// input word layout, lowest field last
	typedef struct packed {
		logic [VB_W-1:0]  valid_bits;
		logic [7:0]       data_byte;
		logic [SYM_W-1:0] leaf_symbol;
		logic             is_leaf;
		logic [IDX_W-1:0] right_child;
		logic [IDX_W-1:0] left_child;
		logic [IDX_W-1:0] node_index;
	} in_word_t;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_idx;
		logic             wr_en;
		logic [IDX_W-1:0] wr_idx;
		entry_t           wr_ent;
	} mem_req_t;

endpackage

// ===== rtl/hufd_node_mem.sv =====
`timescale 1ns / 1ps
// Node table: one write port, one registered read port.
module hufd_node_mem #(
	parameter int NODE_COUNT = hufd_pkg::NODE_COUNT_DEF
) (
	input  logic              clk,
	input  hufd_pkg::mem_req_t req,
	output hufd_pkg::entry_t   rd_data
);
	import hufd_pkg::*;

	localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

	entry_t mem_q [NODE_COUNT];
	entry_t rd_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[AW'(req.wr_idx)] <= req.wr_ent;
		end
		if (req.rd_en) begin
			rd_q <= mem_q[AW'(req.rd_idx)];
		end
	end

	assign rd_data = rd_q;

endmodule

// ===== rtl/hufd_walk.sv =====
`timescale 1ns / 1ps
// Walk sequencer: one child select and table read per code bit, symbol output register.
module hufd_walk #(
	parameter int NODE_COUNT = hufd_pkg::NODE_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [hufd_pkg::IN_W-1:0]     s_tdata,
	input  logic [hufd_pkg::MODE_W-1:0]   s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [hufd_pkg::OUT_W-1:0]    m_tdata,
	output logic                          m_tlast,
	input  logic [hufd_pkg::IDX_W-1:0]    root,
	output hufd_pkg::mem_req_t            req,
	input  hufd_pkg::entry_t              rd_data
);
	import hufd_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_FETCH = 2'd1;
	localparam logic [1:0] ST_NEXT  = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	logic [1:0]       state_q, state_d;
	logic [IDX_W-1:0] cur_q, cur_d;
	logic [7:0]       byte_q, byte_d;
	logic [VB_W-1:0]  nb_q, nb_d;
	logic [SYM_W-1:0] pend_sym_q, pend_sym_d;
	logic             pend_vld_q, pend_vld_d;
	logic             oob_q;
	logic             m_valid_q;
	logic [SYM_W-1:0] m_sym_q;
	logic             m_last_q;

	in_word_t         in_w;
	logic             in_acc;
	entry_t           ent;
	logic [IDX_W-1:0] step_idx;
	logic             can_push;
	logic             push;
	logic             push_last;
	logic             rd_en;
	logic [IDX_W-1:0] rd_idx;
	logic [VB_W-1:0]  nb_sat;
	logic [SYM_W-1:0] sym_sat;

	assign in_w     = in_word_t'(s_tdata);
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign ent      = oob_q ? entry_t'('0) : rd_data;
	assign step_idx = byte_q[7] ? ent.right : ent.left;
	assign can_push = !m_valid_q || m_tready;
	assign nb_sat   = (in_w.valid_bits > BYTE_BITS) ? BYTE_BITS : in_w.valid_bits;
	assign sym_sat  = (32'(in_w.leaf_symbol) >= SYMBOL_COUNT) ?
		SYM_W'(SYMBOL_COUNT - 1) : in_w.leaf_symbol;

	always_comb begin
		req.rd_en  = rd_en;
		req.rd_idx = rd_idx;
		req.wr_en  = in_acc && (s_tuser == MODE_WRITE) &&
			(32'(in_w.node_index) < NODE_COUNT);
		req.wr_idx = in_w.node_index;
		req.wr_ent.sym   = sym_sat;
		req.wr_ent.leaf  = in_w.is_leaf;
		req.wr_ent.right = in_w.right_child;
		req.wr_ent.left  = in_w.left_child;
	end

	always_comb begin
		rd_en      = 1'b0;
		rd_idx     = cur_q;
		push       = 1'b0;
		push_last  = 1'b0;
		state_d    = state_q;
		cur_d      = cur_q;
		byte_d     = byte_q;
		nb_d       = nb_q;
		pend_sym_d = pend_sym_q;
		pend_vld_d = pend_vld_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (s_tuser)
						MODE_DECODE: begin
							byte_d = in_w.data_byte;
							nb_d   = nb_sat;
							if (nb_sat != '0) begin
								rd_en   = 1'b1;
								rd_idx  = cur_q;
								state_d = ST_FETCH;
							end
						end
						MODE_RESTART: begin
							cur_d = root;
						end
						default: ;
					endcase
				end
			end
			ST_FETCH: begin
				rd_en   = 1'b1;
				rd_idx  = step_idx;
				cur_d   = step_idx;
				byte_d  = {byte_q[6:0], 1'b0};
				nb_d    = nb_q - 1'b1;
				state_d = ST_NEXT;
			end
			ST_NEXT: begin
				if (ent.leaf) begin
					// previous symbol of this byte goes out as not-last
					if (!pend_vld_q || can_push) begin
						push       = pend_vld_q;
						pend_sym_d = ent.sym;
						pend_vld_d = 1'b1;
						cur_d      = root;
						if (nb_q != '0) begin
							rd_en   = 1'b1;
							rd_idx  = root;
							state_d = ST_FETCH;
						end else begin
							state_d = ST_FLUSH;
						end
					end
				end else if (nb_q != '0) begin
					rd_en  = 1'b1;
					rd_idx = step_idx;
					cur_d  = step_idx;
					byte_d = {byte_q[6:0], 1'b0};
					nb_d   = nb_q - 1'b1;
				end else begin
					state_d = pend_vld_q ? ST_FLUSH : ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (!pend_vld_q) begin
					state_d = ST_IDLE;
				end else if (can_push) begin
					push       = 1'b1;
					push_last  = 1'b1;
					pend_vld_d = 1'b0;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cur_q      <= '0;
			pend_vld_q <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			cur_q      <= cur_d;
			pend_vld_q <= pend_vld_d;
			if (push) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		byte_q     <= byte_d;
		nb_q       <= nb_d;
		pend_sym_q <= pend_sym_d;
		if (rd_en) begin
			oob_q <= (32'(rd_idx) >= NODE_COUNT);
		end
		if (push) begin
			m_sym_q  <= pend_sym_q;
			m_last_q <= push_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_sym_q;
	assign m_tlast  = m_last_q;

endmodule

// ===== rtl/huffman_tree_walk_decoder.sv =====
`timescale 1ns / 1ps
// Huffman tree-walk decoder top level: root register, node table, walk sequencer.
// A decode word with code bits holds s_tready low until its walk is done, including any
// time a symbol waits on m_tready; one node table read per bit, one root refetch
// per symbol not at the byte's end. Write, restart and empty decode words leave s_tready high.
// Reset clears control, walk position and root to 0; the node table is not cleared.
module huffman_tree_walk_decoder #(
	parameter int NODE_COUNT = hufd_pkg::NODE_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// node_index, left_child, right_child, is_leaf, leaf_symbol, data_byte, valid_bits
	input  logic [hufd_pkg::IN_W-1:0]   s_tdata,
	// mode
	input  logic [hufd_pkg::MODE_W-1:0] s_tuser,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// symbol
	output logic [hufd_pkg::OUT_W-1:0]  m_tdata,
	output logic                        m_tlast,
	input  logic                        cfg_we,
	input  logic [hufd_pkg::IDX_W-1:0]  cfg_wdata
);
	import hufd_pkg::*;

	logic [IDX_W-1:0] root_q;
	mem_req_t         req;
	entry_t           rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= '0;
		end else if (cfg_we) begin
			root_q <= cfg_wdata;
		end
	end

	hufd_node_mem #(
		.NODE_COUNT(NODE_COUNT)
	) u_mem (
		.clk    (clk),
		.req    (req),
		.rd_data(rd_data)
	);

	hufd_walk #(
		.NODE_COUNT(NODE_COUNT)
	) u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.root    (root_q),
		.req     (req),
		.rd_data (rd_data)
	);

endmodule

// ===== rtl/hufd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the Huffman tree-walk decoder, bound to the top level.
module hufd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic [hufd_pkg::IN_W-1:0]   s_tdata,
	input logic [hufd_pkg::MODE_W-1:0] s_tuser,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [hufd_pkg::OUT_W-1:0]  m_tdata,
	input logic                        m_tlast
);
	import hufd_pkg::*;

	// valid_bits sits in the top nibble of the word
	logic [VB_W-1:0] vb;
	assign vb = s_tdata[IN_W-1 -: VB_W];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	a_decode_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == MODE_DECODE) && (vb != '0) |=> !s_tready)
		else $error("decode word with code bits did not occupy the walker");

	a_single_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser != MODE_DECODE) |=> s_tready)
		else $error("write or restart word did not complete in one cycle");

	a_empty_byte: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == MODE_DECODE) && (vb == '0) |=> s_tready)
		else $error("decode word without code bits stalled the input");

endmodule

bind huffman_tree_walk_decoder hufd_checker u_hufd_checker (.*);
